[src/bounded_array_list_top_macros.svh]
// ----------------------------------------------------------------------------
// bounded_array_list_top_macros.svh
// Assertion macros used by the bal_dp module.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ARRAY_LIST_TOP_MACROS_SVH
`define BOUNDED_ARRAY_LIST_TOP_MACROS_SVH

// Condition must hold at every clock edge outside reset
`define BAL_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle
`define BAL_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle
`define BAL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[src/bal_pkg.sv]
// ----------------------------------------------------------------------------
// bal_pkg
// Sizes, request and status codes and control types of the array list.
// ----------------------------------------------------------------------------
package bal_pkg;

    // Storage geometry
    localparam int CAPACITY   = 16;
    localparam int ELEM_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // Port field widths
    localparam int ACT_W   = 3;
    localparam int POS_W   = 5;
    localparam int VAL_W   = 32;
    localparam int FOUND_W = 4;
    localparam int STAT_W  = 2;

    // Request codes
    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND     = 3'd0,
        ACT_INSERT     = 3'd1,
        ACT_REMOVE     = 3'd2,
        ACT_READ       = 3'd3,
        ACT_WRITE      = 3'd4,
        ACT_FIND_FIRST = 3'd5,
        ACT_FIND_LAST  = 3'd6
    } t_action;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_INDEX = 2'd2
    } t_status;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the incoming request
        logic execute;   // apply the request to the list
    } t_dp_cmd;

endpackage

[src/bal_ctrl.sv]
// ----------------------------------------------------------------------------
// bal_ctrl
// Request sequencer: capture, execute, then hold the result beat.
// ----------------------------------------------------------------------------
module bal_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output bal_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_ready) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // Handshake and datapath commands; no beat is taken while in reset
    assign o_ready       = i_rst_n && (r_state == S_IDLE);
    assign o_valid       = (r_state == S_DONE);
    assign o_cmd.capture = o_ready && i_valid;
    assign o_cmd.execute = (r_state == S_EXEC);

endmodule

[src/bal_dp.sv]
// ----------------------------------------------------------------------------
// bal_dp
// List datapath: a row of shifting word cells, fill count, find and result.
// ----------------------------------------------------------------------------
`include "bounded_array_list_top_macros.svh"

module bal_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bal_pkg::t_dp_cmd             i_cmd,
    input  logic [bal_pkg::ACT_W-1:0]    i_action,
    input  logic [bal_pkg::POS_W-1:0]    i_position,
    input  logic [bal_pkg::VAL_W-1:0]    i_value,
    output logic [bal_pkg::VAL_W-1:0]    o_read_value,
    output logic [bal_pkg::FOUND_W-1:0]  o_found_position,
    output logic                         o_hit,
    output logic [bal_pkg::CNT_W-1:0]    o_count,
    output logic [bal_pkg::STAT_W-1:0]   o_status
);

    localparam int CAP = bal_pkg::CAPACITY;
    localparam int EW  = bal_pkg::ELEM_WIDTH;
    localparam int CW  = bal_pkg::CNT_W;

    // Captured request
    bal_pkg::t_action            r_action;
    logic [bal_pkg::POS_W-1:0]   r_pos;
    logic [EW-1:0]               r_val;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= bal_pkg::t_action'(i_action);
            r_pos    <= i_position;
            r_val    <= i_value[EW-1:0];
        end
    end

    // List state
    logic [EW-1:0] r_cell [CAP];
    logic [CW-1:0] r_fill;
    logic [CW-1:0] n_fill;

    // Request decode
    logic full, pos_lt, pos_le;
    logic do_append, do_insert, do_remove, do_write;

    assign full      = (r_fill == CW'(CAP));
    assign pos_lt    = ({1'b0, r_pos} < {1'b0, CW'(r_fill)});
    assign pos_le    = ({1'b0, r_pos} <= {1'b0, CW'(r_fill)});
    assign do_append = (r_action == bal_pkg::ACT_APPEND) && !full;
    assign do_insert = (r_action == bal_pkg::ACT_INSERT) && !full && pos_le;
    assign do_remove = (r_action == bal_pkg::ACT_REMOVE) && pos_lt;
    assign do_write  = (r_action == bal_pkg::ACT_WRITE) && pos_lt;

    // Fill count update
    always_comb begin
        n_fill = r_fill;
        if (do_append || do_insert) n_fill = r_fill + CW'(1);
        else if (do_remove)         n_fill = r_fill - CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)           r_fill <= '0;
        else if (i_cmd.execute) r_fill <= n_fill;
    end

    // Cell row: each cell loads the new word or a neighbor, locally
    for (genvar g = 0; g < CAP; g++) begin : g_cell
        logic [CW-1:0] idx;
        logic [EW-1:0] lower;
        logic [EW-1:0] upper;

        assign idx = CW'(g);

        if (g > 0) begin : g_lo
            assign lower = r_cell[g-1];
        end else begin : g_lo0
            assign lower = '0;
        end

        if (g < CAP - 1) begin : g_up
            assign upper = r_cell[g+1];
        end else begin : g_upn
            assign upper = '0;
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.execute) begin
                if (do_append && idx == r_fill) begin
                    r_cell[g] <= r_val;
                end else if (do_insert && CW'(r_pos) == idx) begin
                    r_cell[g] <= r_val;
                end else if (do_insert && idx > CW'(r_pos) && idx <= r_fill) begin
                    r_cell[g] <= lower;
                end else if (do_remove && idx >= CW'(r_pos) && idx < r_fill - CW'(1)) begin
                    r_cell[g] <= upper;
                end else if (do_write && CW'(r_pos) == idx) begin
                    r_cell[g] <= r_val;
                end
            end
        end
    end

    // Match vector over the occupied cells
    logic [CAP-1:0] match;
    always_comb begin
        for (int i = 0; i < CAP; i++) begin
            match[i] = (r_cell[i] == r_val) && (CW'(i) < r_fill);
        end
    end

    // Priority pick: lowest match and highest match
    logic [bal_pkg::IDX_W-1:0] first_idx, last_idx;
    always_comb begin
        first_idx = '0;
        last_idx  = '0;
        for (int i = CAP - 1; i >= 0; i--) begin
            if (match[i]) first_idx = bal_pkg::IDX_W'(i);
        end
        for (int i = 0; i < CAP; i++) begin
            if (match[i]) last_idx = bal_pkg::IDX_W'(i);
        end
    end

    // Result fields
    logic [bal_pkg::VAL_W-1:0]   n_rd;
    logic [bal_pkg::FOUND_W-1:0] n_found;
    logic                        n_hit;
    bal_pkg::t_status            n_status;

    always_comb begin
        n_rd     = '0;
        n_found  = '0;
        n_hit    = 1'b0;
        n_status = bal_pkg::ST_OK;
        case (r_action)
            bal_pkg::ACT_APPEND: begin
                if (full) n_status = bal_pkg::ST_FULL;
            end
            bal_pkg::ACT_INSERT: begin
                if (full)        n_status = bal_pkg::ST_FULL;
                else if (!pos_le) n_status = bal_pkg::ST_BAD_INDEX;
            end
            bal_pkg::ACT_REMOVE, bal_pkg::ACT_WRITE: begin
                if (!pos_lt) n_status = bal_pkg::ST_BAD_INDEX;
            end
            bal_pkg::ACT_READ: begin
                if (!pos_lt) n_status = bal_pkg::ST_BAD_INDEX;
                else         n_rd = bal_pkg::VAL_W'(r_cell[r_pos[bal_pkg::IDX_W-1:0]]);
            end
            bal_pkg::ACT_FIND_FIRST: begin
                n_hit   = |match;
                n_found = bal_pkg::FOUND_W'(first_idx);
            end
            bal_pkg::ACT_FIND_LAST: begin
                n_hit   = |match;
                n_found = bal_pkg::FOUND_W'(last_idx);
            end
            default: begin
            end
        endcase
    end

    logic [bal_pkg::VAL_W-1:0]   r_rd;
    logic [bal_pkg::FOUND_W-1:0] r_found;
    logic                        r_hit;
    bal_pkg::t_status            r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd     <= '0;
            r_found  <= '0;
            r_hit    <= 1'b0;
            r_status <= bal_pkg::ST_OK;
        end else if (i_cmd.execute) begin
            r_rd     <= n_rd;
            r_found  <= n_found;
            r_hit    <= n_hit;
            r_status <= n_status;
        end
    end

    assign o_read_value     = r_rd;
    assign o_found_position = r_found;
    assign o_hit            = r_hit;
    assign o_count          = r_fill;
    assign o_status         = r_status;

    // Checks
    `BAL_ASSERT_ALWAYS(a_fill_bound, i_clk, i_rst_n, r_fill <= CW'(CAP), "fill above capacity")
    `BAL_ASSERT_NEXT(a_fill_hold, i_clk, i_rst_n, !i_cmd.execute, $stable(r_fill), "fill moved while idle")
    `BAL_ASSERT_IMPLIES(a_full_status, i_clk, i_rst_n, r_status == bal_pkg::ST_FULL, r_fill == CW'(CAP), "full status with room left")

endmodule

[src/bounded_array_list_top.sv]
// ----------------------------------------------------------------------------
// bounded_array_list_top
// Fixed-capacity ordered list of 32-bit words with append, insert, remove,
// read, overwrite, find-first and find-last requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on i_valid/o_ready with i_action, i_position, i_value.
//   Each request yields exactly one result beat on o_valid/i_ready carrying
//   o_read_value, o_found_position, o_hit, o_count and o_status.
//   When the request beat is taken the request is latched; the execute
//   state then updates the cell row and result registers, and the result
//   beat is valid in the result-hold state that follows. One request is in
//   flight at a time: a new request is not taken until the result beat is
//   taken, as the controller steps through its request, update and
//   result-hold states in turn.
//   If the receiver stalls, the result is held unchanged and o_ready stays
//   low until the beat is taken.
//   Reset clears the element count to zero and returns to idle; cell
//   contents are left as they are and are never read before being written.
//   A full list refuses append and insert with a full status; an index
//   out of range gives a bad-index status and changes nothing.
// ----------------------------------------------------------------------------
module bounded_array_list_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [bal_pkg::ACT_W-1:0]    i_action,
    input  logic [bal_pkg::POS_W-1:0]    i_position,
    input  logic [bal_pkg::VAL_W-1:0]    i_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [bal_pkg::VAL_W-1:0]    o_read_value,
    output logic [bal_pkg::FOUND_W-1:0]  o_found_position,
    output logic                         o_hit,
    output logic [bal_pkg::CNT_W-1:0]    o_count,
    output logic [bal_pkg::STAT_W-1:0]   o_status
);

    bal_pkg::t_dp_cmd cmd;

    // Sequencer
    bal_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    // List storage and result logic
    bal_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_action         (i_action),
        .i_position       (i_position),
        .i_value          (i_value),
        .o_read_value     (o_read_value),
        .o_found_position (o_found_position),
        .o_hit            (o_hit),
        .o_count          (o_count),
        .o_status         (o_status)
    );

endmodule
